// File: sv/rsamp_pkg.sv
// ----------------------------------------------------------------------------
// Reservoir sampler package
// Shared widths, generator constants, command and status types.
// ----------------------------------------------------------------------------
package rsamp_pkg;

   localparam int ID_WIDTH       = 32;
   localparam int COUNT_WIDTH    = 32;
   localparam int RNG_WIDTH      = 64;
   localparam int HALF_WIDTH     = RNG_WIDTH / 2;
   localparam int DIV_STEPS      = RNG_WIDTH;
   localparam int STEP_CNT_WIDTH = $clog2(DIV_STEPS);

   localparam logic [RNG_WIDTH-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [RNG_WIDTH-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [RNG_WIDTH-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD,
      OP_XSHIFT,
      OP_MUL_LL,
      OP_MUL_LH,
      OP_MUL_HL,
      OP_DIV_STEP,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      SH_30,
      SH_27,
      SH_31
   } shift_type;

   typedef enum logic {
      MIX_A,
      MIX_B
   } mix_type;

   typedef enum logic [1:0] {
      ST_RUNNING       = 2'd0,
      ST_DONE_OK       = 2'd1,
      ST_NONE_FOUND    = 2'd2,
      ST_NONE_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      op_type    op;
      shift_type shift;
      mix_type   mix;
   } cmd_type;

   typedef struct packed {
      logic needs_draw;
   } stat_type;

endpackage

// File: sv/rsamp_ctrl.sv
// ----------------------------------------------------------------------------
// Reservoir sampler controller
// Sequences accept, generator mixing, the remainder steps and the result beat.
// ----------------------------------------------------------------------------
module rsamp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsamp_pkg::stat_type stat,
   output rsamp_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_LOAD,
      S_XS1,
      S_M1_LL,
      S_M1_LH,
      S_M1_HL,
      S_XS2,
      S_M2_LL,
      S_M2_LH,
      S_M2_HL,
      S_XS3,
      S_DIV,
      S_FINISH
   } state_type;

   state_type                              state_ff;
   logic                                   rsp_valid_ff;
   logic [rsamp_pkg::STEP_CNT_WIDTH-1:0]   step_cnt_ff;
   logic                                   out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op    = rsamp_pkg::OP_NONE;
      cmd.shift = rsamp_pkg::SH_30;
      cmd.mix   = rsamp_pkg::MIX_A;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? rsamp_pkg::OP_ACCEPT : rsamp_pkg::OP_NONE;
         S_DECIDE: cmd.op = rsamp_pkg::OP_NONE;
         S_LOAD:   cmd.op = rsamp_pkg::OP_LOAD;
         S_XS1: begin
            cmd.op    = rsamp_pkg::OP_XSHIFT;
            cmd.shift = rsamp_pkg::SH_30;
         end
         S_M1_LL:  cmd.op = rsamp_pkg::OP_MUL_LL;
         S_M1_LH:  cmd.op = rsamp_pkg::OP_MUL_LH;
         S_M1_HL:  cmd.op = rsamp_pkg::OP_MUL_HL;
         S_XS2: begin
            cmd.op    = rsamp_pkg::OP_XSHIFT;
            cmd.shift = rsamp_pkg::SH_27;
         end
         S_M2_LL: begin
            cmd.op  = rsamp_pkg::OP_MUL_LL;
            cmd.mix = rsamp_pkg::MIX_B;
         end
         S_M2_LH: begin
            cmd.op  = rsamp_pkg::OP_MUL_LH;
            cmd.mix = rsamp_pkg::MIX_B;
         end
         S_M2_HL: begin
            cmd.op  = rsamp_pkg::OP_MUL_HL;
            cmd.mix = rsamp_pkg::MIX_B;
         end
         S_XS3: begin
            cmd.op    = rsamp_pkg::OP_XSHIFT;
            cmd.shift = rsamp_pkg::SH_31;
         end
         S_DIV:    cmd.op = rsamp_pkg::OP_DIV_STEP;
         S_FINISH: cmd.op = out_free ? rsamp_pkg::OP_FINISH : rsamp_pkg::OP_NONE;
         default:  cmd.op = rsamp_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_cnt_ff  <= '0;
      end else begin
         if ((state_ff == S_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: state_ff <= stat.needs_draw ? S_LOAD : S_FINISH;
            S_LOAD:   state_ff <= S_XS1;
            S_XS1:    state_ff <= S_M1_LL;
            S_M1_LL:  state_ff <= S_M1_LH;
            S_M1_LH:  state_ff <= S_M1_HL;
            S_M1_HL:  state_ff <= S_XS2;
            S_XS2:    state_ff <= S_M2_LL;
            S_M2_LL:  state_ff <= S_M2_LH;
            S_M2_LH:  state_ff <= S_M2_HL;
            S_M2_HL:  state_ff <= S_XS3;
            S_XS3: begin
               step_cnt_ff <= '0;
               state_ff    <= S_DIV;
            end
            S_DIV: begin
               step_cnt_ff <= step_cnt_ff + 1'b1;
               if (step_cnt_ff == rsamp_pkg::STEP_CNT_WIDTH'(rsamp_pkg::DIV_STEPS - 1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: sv/rsamp_dp.sv
// ----------------------------------------------------------------------------
// Reservoir sampler datapath
// Generator state, shared 32x32 multiplier, restoring remainder unit and
// reservoir registers.
// ----------------------------------------------------------------------------
module rsamp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rsamp_pkg::cmd_type                  cmd,
   output rsamp_pkg::stat_type                 stat,
   input  logic [rsamp_pkg::ID_WIDTH-1:0]      req_item_id,
   input  logic                                req_eligible,
   input  logic                                req_too_long,
   input  logic                                req_last,
   input  logic                                csr_wr_en,
   input  logic [rsamp_pkg::RNG_WIDTH-1:0]     csr_wr_data,
   output logic [rsamp_pkg::ID_WIDTH-1:0]      rsp_chosen_id,
   output logic [rsamp_pkg::COUNT_WIDTH-1:0]   rsp_count_seen,
   output logic                                rsp_replaced,
   output logic [1:0]                          rsp_status
);

   localparam int RW = rsamp_pkg::RNG_WIDTH;
   localparam int HW = rsamp_pkg::HALF_WIDTH;
   localparam int CW = rsamp_pkg::COUNT_WIDTH;

   logic [RW-1:0]                    rng_ff;
   logic [RW-1:0]                    z_ff;
   logic [RW-1:0]                    acc_ff;
   logic [CW-1:0]                    rem_ff;
   logic [CW-1:0]                    count_ff;
   logic                             trunc_ff;
   logic [rsamp_pkg::ID_WIDTH-1:0]   kept_ff;
   logic [rsamp_pkg::ID_WIDTH-1:0]   item_id_ff;
   logic                             draw_ff;
   logic                             last_ff;

   logic [rsamp_pkg::ID_WIDTH-1:0]   chosen_ff;
   logic [CW-1:0]                    count_out_ff;
   logic                             replaced_ff;
   rsamp_pkg::status_type            status_ff;

   logic [RW-1:0]                    rng_in;
   logic [RW-1:0]                    mix_const;
   logic [HW-1:0]                    mul_a;
   logic [HW-1:0]                    mul_b;
   logic [RW-1:0]                    prod;
   logic [RW-1:0]                    z_shifted;
   logic [CW:0]                      trial;
   logic [CW-1:0]                    trial_diff;
   logic [CW-1:0]                    rem_in;
   logic                             hit;
   rsamp_pkg::status_type            status_in;

   assign stat.needs_draw = draw_ff;
   assign rng_in          = rng_ff + rsamp_pkg::GOLDEN_GAMMA;

   assign mix_const = (cmd.mix == rsamp_pkg::MIX_B) ? rsamp_pkg::MIX_MUL_B
                                                    : rsamp_pkg::MIX_MUL_A;
   assign mul_a     = (cmd.op == rsamp_pkg::OP_MUL_HL) ? z_ff[RW-1:HW] : z_ff[HW-1:0];
   assign mul_b     = (cmd.op == rsamp_pkg::OP_MUL_LH) ? mix_const[RW-1:HW]
                                                       : mix_const[HW-1:0];
   assign prod      = mul_a * mul_b;

   always_comb begin
      unique case (cmd.shift)
         rsamp_pkg::SH_30: z_shifted = z_ff ^ (z_ff >> 30);
         rsamp_pkg::SH_27: z_shifted = z_ff ^ (z_ff >> 27);
         rsamp_pkg::SH_31: z_shifted = z_ff ^ (z_ff >> 31);
         default:          z_shifted = z_ff ^ (z_ff >> 31);
      endcase
   end

   assign trial      = {rem_ff, z_ff[RW-1]};
   assign trial_diff = trial[CW-1:0] - count_ff;
   assign rem_in     = (trial >= {1'b0, count_ff}) ? trial_diff : trial[CW-1:0];
   assign hit        = draw_ff && (rem_ff == '0);

   always_comb begin
      priority if (!last_ff) begin
         status_in = rsamp_pkg::ST_RUNNING;
      end else if (count_ff != '0) begin
         status_in = rsamp_pkg::ST_DONE_OK;
      end else if (trunc_ff) begin
         status_in = rsamp_pkg::ST_NONE_TOO_LONG;
      end else begin
         status_in = rsamp_pkg::ST_NONE_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff   <= '0;
         count_ff <= '0;
         trunc_ff <= 1'b0;
         kept_ff  <= '0;
         draw_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rng_ff <= csr_wr_data;
         end
         unique case (cmd.op)
            rsamp_pkg::OP_ACCEPT: begin
               item_id_ff <= req_item_id;
               last_ff    <= req_last;
               draw_ff    <= req_eligible && !req_too_long;
               if (req_too_long) begin
                  trunc_ff <= 1'b1;
               end else if (req_eligible && (count_ff != rsamp_pkg::COUNT_MAX)) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            rsamp_pkg::OP_LOAD: begin
               rng_ff <= rng_in;
               z_ff   <= rng_in;
               rem_ff <= '0;
            end
            rsamp_pkg::OP_XSHIFT: z_ff <= z_shifted;
            rsamp_pkg::OP_MUL_LL: acc_ff <= prod;
            rsamp_pkg::OP_MUL_LH: acc_ff[RW-1:HW] <= acc_ff[RW-1:HW] + prod[HW-1:0];
            rsamp_pkg::OP_MUL_HL: z_ff <= {acc_ff[RW-1:HW] + prod[HW-1:0], acc_ff[HW-1:0]};
            rsamp_pkg::OP_DIV_STEP: begin
               rem_ff <= rem_in;
               z_ff   <= {z_ff[RW-2:0], 1'b0};
            end
            rsamp_pkg::OP_FINISH: begin
               chosen_ff    <= hit ? item_id_ff : kept_ff;
               count_out_ff <= count_ff;
               replaced_ff  <= hit;
               status_ff    <= status_in;
               if (hit) begin
                  kept_ff <= item_id_ff;
               end
               if (last_ff) begin
                  count_ff <= '0;
                  trunc_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_chosen_id  = chosen_ff;
   assign rsp_count_seen = count_out_ff;
   assign rsp_replaced   = replaced_ff;
   assign rsp_status     = status_ff;

endmodule

// File: sv/reservoir_sample_one_item.sv
// ----------------------------------------------------------------------------
// One-item reservoir sampler
// Keeps one uniformly chosen candidate id per run using a splitmix64 draw.
// ----------------------------------------------------------------------------
// An item with neither flag set, or with too_long set, skips the draw and goes
// from accept through the decide state to its result beat. An eligible item
// draws a new generator value: six passes through one shared 32x32 multiplier
// for the two 64-bit mixing products, then a restoring remainder unit that
// reduces the draw modulo the seen count, one bit per cycle. A new item is
// accepted while an earlier result beat is still stalled. Writing the seed
// loads the generator at once; the user must make writes only while the block
// is idle, and the block itself does not enforce this.
module reservoir_sample_one_item (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rsamp_pkg::ID_WIDTH-1:0]      req_item_id,
   input  logic                                req_eligible,
   input  logic                                req_too_long,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rsamp_pkg::ID_WIDTH-1:0]      rsp_chosen_id,
   output logic [rsamp_pkg::COUNT_WIDTH-1:0]   rsp_count_seen,
   output logic                                rsp_replaced,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_wr_en,
   input  logic [rsamp_pkg::RNG_WIDTH-1:0]     csr_wr_data
);

   rsamp_pkg::cmd_type  cmd;
   rsamp_pkg::stat_type stat;

   rsamp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsamp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_item_id    (req_item_id),
      .req_eligible   (req_eligible),
      .req_too_long   (req_too_long),
      .req_last       (req_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_chosen_id  (rsp_chosen_id),
      .rsp_count_seen (rsp_count_seen),
      .rsp_replaced   (rsp_replaced),
      .rsp_status     (rsp_status)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an accepted beat");

   a_done_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rsamp_pkg::ST_DONE_OK) |-> (rsp_count_seen != '0))
      else $error("done status with zero count");

   a_none_has_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == rsamp_pkg::ST_NONE_FOUND ||
                     rsp_status == rsamp_pkg::ST_NONE_TOO_LONG))
      |-> (rsp_count_seen == '0))
      else $error("empty-run status with nonzero count");

   a_replace_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_replaced) |-> (rsp_count_seen != '0))
      else $error("replacement reported with zero count");
`endif

endmodule
